// File: rtl/lfpg_pkg.sv
// ----------------------------------------------------------------------------
// lfpg_pkg
// Shared types and constants for the LED flash pattern generator.
// ----------------------------------------------------------------------------
package lfpg_pkg;

    localparam int TIME_WIDTH = 16;
    localparam int CFG_W      = 16;
    localparam int CNT_W      = 17;
    localparam int CMP_W      = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;
    localparam int CFG_IDX_W  = 3;
    localparam int MODE_W     = 3;
    localparam int FLASH_W    = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF         = 3'd0,
        MODE_STARTUP     = 3'd1,
        MODE_UNSUPPORTED = 3'd2,
        MODE_DETECT      = 3'd3,
        MODE_ERROR       = 3'd4
    } mode_t;

    typedef enum logic {
        OP_TICK     = 1'b0,
        OP_SET_MODE = 1'b1
    } op_t;

    localparam logic [CFG_IDX_W-1:0] CFG_UNSUPPORTED_BLINK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DETECT_ON         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DETECT_OFF        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_BLINK       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_DELAY     = 3'd4;

    localparam logic [CFG_W-1:0] RST_UNSUPPORTED_BLINK = 16'd100;
    localparam logic [CFG_W-1:0] RST_DETECT_ON         = 16'd100;
    localparam logic [CFG_W-1:0] RST_DETECT_OFF        = 16'd1000;
    localparam logic [CFG_W-1:0] RST_ERROR_BLINK       = 16'd500;
    localparam logic [CFG_W-1:0] RST_STARTUP_DELAY     = 16'd500;

    typedef struct packed {
        logic [CFG_W-1:0] unsupported_blink_ms;
        logic [CFG_W-1:0] detect_on_ms;
        logic [CFG_W-1:0] detect_off_ms;
        logic [CFG_W-1:0] error_blink_ms;
        logic [CFG_W-1:0] startup_delay_ms;
    } cfg_t;

    typedef struct packed {
        op_t               op;
        logic [MODE_W-1:0] new_mode;
    } item_t;

    typedef struct packed {
        logic  led_on;
        mode_t mode_now;
    } result_t;

    typedef struct packed {
        mode_t                 mode;
        logic [CNT_W-1:0]      phase_counter;
        logic                  phase_is_on;
        logic [FLASH_W-1:0]    flashes_done;
        logic                  led_pin;
        logic [CFG_W-1:0]      on_time;
        logic [CFG_W-1:0]      off_time;
        logic [FLASH_W-1:0]    flash_count;
        logic [TIME_WIDTH-1:0] uptime;
    } core_state_t;

endpackage

// File: rtl/lfpg_cfg_regs.sv
// ----------------------------------------------------------------------------
// lfpg_cfg_regs
// Timing register file, written through a plain index/data port.
// ----------------------------------------------------------------------------
module lfpg_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [lfpg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lfpg_pkg::CFG_W-1:0]     cfg_wdata,
    output lfpg_pkg::cfg_t                 cfg
);

    lfpg_pkg::cfg_t cfg_reg;
    lfpg_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                lfpg_pkg::CFG_UNSUPPORTED_BLINK: cfg_next.unsupported_blink_ms = cfg_wdata;
                lfpg_pkg::CFG_DETECT_ON:         cfg_next.detect_on_ms         = cfg_wdata;
                lfpg_pkg::CFG_DETECT_OFF:        cfg_next.detect_off_ms        = cfg_wdata;
                lfpg_pkg::CFG_ERROR_BLINK:       cfg_next.error_blink_ms       = cfg_wdata;
                lfpg_pkg::CFG_STARTUP_DELAY:     cfg_next.startup_delay_ms     = cfg_wdata;
                default:                         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.unsupported_blink_ms <= lfpg_pkg::RST_UNSUPPORTED_BLINK;
            cfg_reg.detect_on_ms         <= lfpg_pkg::RST_DETECT_ON;
            cfg_reg.detect_off_ms        <= lfpg_pkg::RST_DETECT_OFF;
            cfg_reg.error_blink_ms       <= lfpg_pkg::RST_ERROR_BLINK;
            cfg_reg.startup_delay_ms     <= lfpg_pkg::RST_STARTUP_DELAY;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/lfpg_core.sv
// ----------------------------------------------------------------------------
// lfpg_core
// Mode and flash phase state with its single-step update per item.
// ----------------------------------------------------------------------------
module lfpg_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  lfpg_pkg::item_t   item,
    input  lfpg_pkg::cfg_t    cfg,
    output lfpg_pkg::result_t result
);

    lfpg_pkg::core_state_t state_reg;
    lfpg_pkg::core_state_t state_next;

    lfpg_pkg::mode_t                 mode_sel;
    logic [lfpg_pkg::TIME_WIDTH-1:0] uptime_inc;
    logic [lfpg_pkg::CNT_W-1:0]      cnt_inc;
    logic                            on_expired;
    logic                            off_expired;

    assign mode_sel = (item.new_mode > lfpg_pkg::MODE_ERROR) ? lfpg_pkg::MODE_ERROR
                                                             : lfpg_pkg::mode_t'(item.new_mode);
    assign uptime_inc = (state_reg.uptime == {lfpg_pkg::TIME_WIDTH{1'b1}}) ? state_reg.uptime
                        : state_reg.uptime + lfpg_pkg::TIME_WIDTH'(1);
    assign cnt_inc     = state_reg.phase_counter + lfpg_pkg::CNT_W'(1);
    assign on_expired  = state_reg.phase_counter >= lfpg_pkg::CNT_W'(state_reg.on_time);
    assign off_expired = state_reg.phase_counter >= lfpg_pkg::CNT_W'(state_reg.off_time);

    always_comb begin
        state_next = state_reg;
        if (step_en) begin
            if (item.op == lfpg_pkg::OP_SET_MODE) begin
                state_next.mode = mode_sel;
                unique case (mode_sel)
                    lfpg_pkg::MODE_OFF: begin
                        state_next.phase_counter = {lfpg_pkg::CNT_W{1'b1}};
                        state_next.flashes_done  = '0;
                        state_next.phase_is_on   = 1'b0;
                        state_next.led_pin       = 1'b0;
                    end
                    lfpg_pkg::MODE_UNSUPPORTED: begin
                        state_next.on_time     = cfg.unsupported_blink_ms;
                        state_next.off_time    = cfg.unsupported_blink_ms;
                        state_next.flash_count = lfpg_pkg::FLASH_W'(1);
                    end
                    lfpg_pkg::MODE_DETECT: begin
                        state_next.on_time     = cfg.detect_on_ms;
                        state_next.off_time    = cfg.detect_off_ms;
                        state_next.flash_count = lfpg_pkg::FLASH_W'(2);
                    end
                    default: begin
                        state_next.on_time     = cfg.error_blink_ms;
                        state_next.off_time    = cfg.error_blink_ms;
                        state_next.flash_count = lfpg_pkg::FLASH_W'(1);
                    end
                endcase
            end else begin
                state_next.uptime = uptime_inc;
                if (state_reg.mode == lfpg_pkg::MODE_STARTUP) begin
                    if (lfpg_pkg::CMP_W'(uptime_inc) >=
                        lfpg_pkg::CMP_W'(cfg.startup_delay_ms)) begin
                        state_next.mode          = lfpg_pkg::MODE_OFF;
                        state_next.phase_counter = {lfpg_pkg::CNT_W{1'b1}};
                        state_next.flashes_done  = '0;
                        state_next.phase_is_on   = 1'b0;
                        state_next.led_pin       = 1'b0;
                    end
                end else if (state_reg.mode != lfpg_pkg::MODE_OFF) begin
                    if (state_reg.phase_is_on) begin
                        if (on_expired) begin
                            if (state_reg.flashes_done != {lfpg_pkg::FLASH_W{1'b1}}) begin
                                state_next.flashes_done = state_reg.flashes_done
                                                          + lfpg_pkg::FLASH_W'(1);
                            end
                            state_next.phase_counter = '0;
                            state_next.phase_is_on   = 1'b0;
                            state_next.led_pin       = 1'b0;
                        end else begin
                            state_next.phase_counter = cnt_inc;
                        end
                    end else if (state_reg.flashes_done >= state_reg.flash_count) begin
                        if (off_expired) begin
                            state_next.flashes_done  = '0;
                            state_next.phase_counter = '0;
                            state_next.phase_is_on   = 1'b1;
                            state_next.led_pin       = 1'b1;
                        end else begin
                            state_next.phase_counter = cnt_inc;
                        end
                    end else begin
                        if (on_expired) begin
                            state_next.phase_counter = '0;
                            state_next.phase_is_on   = 1'b1;
                            state_next.led_pin       = 1'b1;
                        end else begin
                            state_next.phase_counter = cnt_inc;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode          <= lfpg_pkg::MODE_STARTUP;
            state_reg.phase_counter <= '0;
            state_reg.phase_is_on   <= 1'b0;
            state_reg.flashes_done  <= '0;
            state_reg.led_pin       <= 1'b1;
            state_reg.on_time       <= '0;
            state_reg.off_time      <= '0;
            state_reg.flash_count   <= '0;
            state_reg.uptime        <= '0;
        end else begin
            state_reg <= state_next;
        end
    end

    assign result.led_on   = state_next.led_pin;
    assign result.mode_now = state_next.mode;

endmodule

// File: rtl/led_flash_pattern_generator_unit.sv
// ----------------------------------------------------------------------------
// led_flash_pattern_generator_unit
// Fault LED flash pattern generator: tick and mode items in, LED level out.
//
//   channel  direction  payload
//   s_*      in         tuser[0] op, tdata[2:0] new_mode
//   m_*      out        tdata[0] led_on, tdata[3:1] mode_now
//   cfg_*    in         index 0..4 timing registers, 16-bit data
//
// one item per cycle sustained while m_tready does not stall the result; each item
// passes through the input register and then the result register around the state update
// synchronous active-low reset returns startup mode with the LED lit
// a stalled result holds while one more item waits in the input register
// ----------------------------------------------------------------------------
module led_flash_pattern_generator_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,  // new_mode[2:0], zero pad
    input  logic [0:0]                     s_tuser,  // op[0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,  // led_on[0], mode_now[3:1], zero pad
    input  logic                           cfg_wr_en,
    input  logic [lfpg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lfpg_pkg::CFG_W-1:0]     cfg_wdata
);

    lfpg_pkg::cfg_t    cfg;
    lfpg_pkg::result_t core_result;

    logic              in_valid_reg;
    logic              in_valid_next;
    lfpg_pkg::item_t   in_item_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    lfpg_pkg::result_t out_result_reg;
    logic              s_xfer;
    logic              advance;

    lfpg_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    lfpg_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_xfer) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_item_reg.op       <= lfpg_pkg::op_t'(s_tuser[0]);
            in_item_reg.new_mode <= s_tdata[lfpg_pkg::MODE_W-1:0];
        end
        if (advance) begin
            out_result_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_result_reg.mode_now, out_result_reg.led_on};

    // off mode never shows a lit LED
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[3:1] == lfpg_pkg::MODE_OFF)) |-> !m_tdata[0])
        else $error("lit LED reported in off mode");

    // an item leaving the input register becomes a visible result
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("result lost after state update");

    // an empty input register always takes a transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input stalled with empty input register");

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the LED flash pattern generator: a short directed run through
// every mode code and the startup hand-over, random phases of ticks and
// mode changes under changing timings, then a short startup wait at the
// longest delay. Each result is compared against an in-bench model of the LED
// pattern, with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module tb;
    import lfpg_pkg::*;

    localparam logic [CFG_W-1:0]  MS_MAX    = '1;
    localparam logic [MODE_W-1:0] CODE_LAST = '1;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;  // new_mode[2:0], zero pad
    logic [0:0]           s_tuser   = '0;  // op[0]
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [7:0]           m_tdata;         // led_on[0], mode_now[3:1], zero pad
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    led_flash_pattern_generator_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // pattern model state
    cfg_t                  regs;
    mode_t                 cur_mode;
    logic [CNT_W-1:0]      phase_cnt;
    logic                  lit_phase;
    logic [FLASH_W-1:0]    flashes;
    logic                  led_level;
    logic [CFG_W-1:0]      on_ms;
    logic [CFG_W-1:0]      off_ms;
    logic [FLASH_W-1:0]    group_len;
    logic [TIME_WIDTH-1:0] up_ms;

    item_t       pending_q[$];
    result_t     expected_led_q[$];
    int unsigned errors = 0;
    int unsigned send_gap;
    int unsigned hold_gap;
    bit          quiet = 1'b0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 50) begin
            $display("tb: mismatch at %0t: %s", $realtime, msg);
        end
    endtask

    function automatic void reset_model();
        regs.unsupported_blink_ms = RST_UNSUPPORTED_BLINK;
        regs.detect_on_ms         = RST_DETECT_ON;
        regs.detect_off_ms        = RST_DETECT_OFF;
        regs.error_blink_ms       = RST_ERROR_BLINK;
        regs.startup_delay_ms     = RST_STARTUP_DELAY;
        cur_mode  = MODE_STARTUP;
        phase_cnt = '0;
        lit_phase = 1'b0;
        flashes   = '0;
        led_level = 1'b1;
        on_ms     = '0;
        off_ms    = '0;
        group_len = '0;
        up_ms     = '0;
    endfunction

    function automatic void set_mode(input logic [MODE_W-1:0] code);
        cur_mode = (code > MODE_ERROR) ? MODE_ERROR : mode_t'(code);
        case (cur_mode)
            MODE_OFF: begin
                phase_cnt = '1;
                flashes   = '0;
                lit_phase = 1'b0;
                led_level = 1'b0;
            end
            MODE_UNSUPPORTED: begin
                on_ms     = regs.unsupported_blink_ms;
                off_ms    = regs.unsupported_blink_ms;
                group_len = 2'd1;
            end
            MODE_DETECT: begin
                on_ms     = regs.detect_on_ms;
                off_ms    = regs.detect_off_ms;
                group_len = 2'd2;
            end
            default: begin
                on_ms     = regs.error_blink_ms;
                off_ms    = regs.error_blink_ms;
                group_len = 2'd1;
            end
        endcase
    endfunction

    // compare, then advance the phase counter
    function automatic logic phase_over(input logic [CFG_W-1:0] limit);
        logic hit;
        hit = phase_cnt >= {1'b0, limit};
        phase_cnt = phase_cnt + 1'b1;
        return hit;
    endfunction

    function automatic void tick_ms();
        if (up_ms != '1) up_ms = up_ms + 1'b1;
        if (cur_mode == MODE_OFF) return;
        if (cur_mode == MODE_STARTUP) begin
            if (up_ms >= regs.startup_delay_ms) set_mode(MODE_OFF);
            return;
        end
        if (lit_phase) begin
            if (phase_over(on_ms)) begin
                if (flashes != 2'd3) flashes = flashes + 1'b1;
                phase_cnt = '0;
                lit_phase = 1'b0;
                led_level = 1'b0;
            end
        end else if (flashes >= group_len) begin
            if (phase_over(off_ms)) begin
                flashes   = '0;
                phase_cnt = '0;
                lit_phase = 1'b1;
                led_level = 1'b1;
            end
        end else if (phase_over(on_ms)) begin
            phase_cnt = '0;
            lit_phase = 1'b1;
            led_level = 1'b1;
        end
    endfunction

    function automatic void pattern_step(input item_t it);
        result_t r;
        if (it.op == OP_SET_MODE) set_mode(it.new_mode);
        else tick_ms();
        r.led_on   = led_level;
        r.mode_now = cur_mode;
        expected_led_q.push_back(r);
    endfunction

    // mostly short gaps, a few long ones
    function automatic int unsigned idle_len();
        int unsigned r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge aclk) begin : drive
        item_t taken;
        item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                taken.op       = op_t'(s_tuser[0]);
                taken.new_mode = s_tdata[MODE_W-1:0];
                pattern_step(taken);
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_q.size() != 0) begin
                    nxt = pending_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {5'b0, nxt.new_mode};
                    s_tuser  <= nxt.op;
                    send_gap = idle_len();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : watch
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_gap = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_led_q.size() == 0) begin
                    report_mismatch($sformatf("transfer with none expected, tdata %h", m_tdata));
                end else begin
                    want = expected_led_q.pop_front();
                    if (m_tdata[0] !== want.led_on) begin
                        report_mismatch($sformatf("led_on %b, expected %b",
                                                  m_tdata[0], want.led_on));
                    end
                    if (m_tdata[3:1] !== want.mode_now) begin
                        report_mismatch($sformatf("mode_now %0d, expected %0d",
                                                  m_tdata[3:1], want.mode_now));
                    end
                end
            end
            if (hold_gap != 0) begin
                hold_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                hold_gap = idle_len();
            end
        end
    end

    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_q.size() != 0 || s_tvalid || expected_led_q.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_UNSUPPORTED_BLINK: regs.unsupported_blink_ms = val;
            CFG_DETECT_ON:         regs.detect_on_ms         = val;
            CFG_DETECT_OFF:        regs.detect_off_ms        = val;
            CFG_ERROR_BLINK:       regs.error_blink_ms       = val;
            CFG_STARTUP_DELAY:     regs.startup_delay_ms     = val;
            default: ;
        endcase
    endtask

    task automatic push_ticks(input int unsigned n);
        item_t it;
        it.op       = OP_TICK;
        it.new_mode = '0;
        repeat (n) pending_q.push_back(it);
    endtask

    task automatic push_mode(input logic [MODE_W-1:0] code);
        item_t it;
        it.op       = OP_SET_MODE;
        it.new_mode = code;
        pending_q.push_back(it);
    endtask

    // flash modes mostly, some off and startup, a few undefined codes
    function automatic logic [MODE_W-1:0] pick_code();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 3) return MODE_OFF;
        if (r < 5) return MODE_STARTUP;
        if (r < 6) return MODE_W'($urandom_range(MODE_ERROR + 1, CODE_LAST));
        return MODE_W'($urandom_range(MODE_UNSUPPORTED, MODE_ERROR));
    endfunction

    function automatic logic [CFG_W-1:0] pick_ms(input int style);
        case (style)
            0: return '0;
            1: return MS_MAX;
            2: return $urandom_range(0, 1) ? MS_MAX : '0;
            3: return CFG_W'($urandom_range(0, 40));
            default: return CFG_W'($urandom_range(0, 6));
        endcase
    endfunction

    initial begin
        int unsigned      n;
        int unsigned      rand_items;
        int               style;
        logic [CFG_W-1:0] d;

        reset_model();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: startup hand-over, every mode code, off pre-arm
        wait_idle();
        write_reg(CFG_STARTUP_DELAY, 16'd8);
        push_ticks(2);
        push_mode(MODE_STARTUP);
        push_mode(CODE_LAST);
        push_mode(MODE_W'(MODE_ERROR + 1));
        push_mode(CODE_LAST - 3'd1);
        push_mode(MODE_STARTUP);
        push_ticks(7);
        push_mode(MODE_UNSUPPORTED);
        push_ticks(1);
        push_mode(MODE_DETECT);
        push_ticks(1);
        push_mode(MODE_ERROR);
        push_ticks(1);
        push_mode(MODE_OFF);
        push_ticks(1);

        rand_items = 0;
        while (rand_items < 2000) begin
            wait_idle();
            style = $urandom_range(0, 9);
            write_reg(CFG_UNSUPPORTED_BLINK, pick_ms(style));
            write_reg(CFG_DETECT_ON, pick_ms(style));
            write_reg(CFG_DETECT_OFF, pick_ms(style));
            write_reg(CFG_ERROR_BLINK, pick_ms(style));
            if ($urandom_range(0, 2) != 0) begin
                d = (up_ms > MS_MAX - 30) ? MS_MAX : up_ms + CFG_W'($urandom_range(0, 30));
            end else begin
                d = pick_ms(style);
            end
            write_reg(CFG_STARTUP_DELAY, d);
            quiet = ($urandom_range(0, 3) == 0);
            push_mode(pick_code());
            n = $urandom_range(60, 140);
            repeat (n) begin
                if ($urandom_range(0, 9) == 0) push_mode(pick_code());
                else push_ticks(1);
            end
            rand_items += n + 1;
        end

        // startup at the longest delay, then flash and startup again
        wait_idle();
        write_reg(CFG_UNSUPPORTED_BLINK, 16'd3);
        write_reg(CFG_STARTUP_DELAY, MS_MAX);
        quiet = 1'b1;
        push_mode(MODE_STARTUP);
        push_ticks(20);
        push_mode(MODE_UNSUPPORTED);
        push_ticks(5);
        push_mode(MODE_STARTUP);
        push_ticks(3);

        wait_idle();
        repeat (10) @(posedge aclk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
